FILE: src/nec_pkg.sv
// Shared types and constants for the NEC infrared frame decoder.
package nec_pkg;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_LEADER = 3'd1,
		PH_CODE   = 3'd2,
		PH_REP1   = 3'd3,
		PH_REP2   = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		REG_ADDRESS_A     = 3'd0,
		REG_ADDRESS_B     = 3'd1,
		REG_CHANNEL_MASK  = 3'd2,
		REG_GLITCH_FILTER = 3'd3,
		REG_TIMEOUT_TICKS = 3'd4,
		REG_REPEAT_DELAY  = 3'd5
	} reg_index_t;

	localparam logic [15:0] ADDRESS_A_RESET     = 16'd31879;
	localparam logic [15:0] ADDRESS_B_RESET     = 16'd3974;
	localparam logic [7:0]  CHANNEL_MASK_RESET  = 8'hFF;
	localparam logic        GLITCH_FILTER_RESET = 1'b1;
	localparam logic [7:0]  TIMEOUT_TICKS_RESET = 8'd130;
	localparam logic [2:0]  REPEAT_DELAY_RESET  = 3'd5;

	localparam logic [15:0] LEADER_ABOVE  = 16'd124;
	localparam logic [15:0] LEADER_BELOW  = 16'd149;
	localparam logic [15:0] BIT_ABOVE     = 16'd8;
	localparam logic [15:0] BIT_BELOW     = 16'd30;
	localparam logic [15:0] BIT_ONE_MIN   = 16'd17;
	localparam logic [15:0] REPEAT_MIN    = 16'd100;
	localparam logic [15:0] REPEAT_MAX    = 16'd130;
	localparam logic [15:0] GLITCH_MAX    = 16'd1;
	localparam logic [5:0]  FRAME_BITS    = 6'd32;

	localparam logic [7:0] CMD_REP_0 = 8'h88;
	localparam logic [7:0] CMD_REP_1 = 8'h8C;
	localparam logic [7:0] CMD_REP_2 = 8'h29;
	localparam logic [7:0] CMD_REP_3 = 8'h2A;

	function automatic logic is_repeatable(input logic [7:0] cmd);
		return (cmd == CMD_REP_0) || (cmd == CMD_REP_1) ||
			(cmd == CMD_REP_2) || (cmd == CMD_REP_3);
	endfunction

endpackage

FILE: src/nec_ir_frame_decoder.sv
// Throughput: one input transaction per cycle, unless a pending result is held by a low m_tready.
// The decoder state is updated combinationally between an input register and a result register.
// Reset (arst_n low, asynchronous) clears the pipeline valid flags and decoder state and
// loads the configuration registers with their reset values.
// Top level of the NEC infrared frame decoder.
module nec_ir_frame_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] interval
	input  logic        s_tuser,   // [0] func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] command
	output logic        m_tuser,   // [0] repeated
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_wdata
);

	logic [15:0] address_a_q;
	logic [15:0] address_b_q;
	logic [7:0]  channel_mask_q;
	logic        glitch_filter_q;
	logic [7:0]  timeout_ticks_q;
	logic [2:0]  repeat_delay_q;

	logic        valid_s1;
	logic        func_s1;
	logic [15:0] interval_s1;

	logic        out_valid_q;
	logic [7:0]  out_command_q;
	logic        out_repeated_q;

	nec_pkg::phase_t phase_q, phase_d;
	logic [31:0] shift_word_q, shift_word_d;
	logic [5:0]  bit_count_q, bit_count_d;
	logic [7:0]  repeat_command_q, repeat_command_d;
	logic [2:0]  repeat_left_q, repeat_left_d;
	logic [7:0]  quiet_ticks_q, quiet_ticks_d;

	logic        emit;
	logic [7:0]  emit_command;
	logic        emit_repeated;

	logic        advance;
	logic        bit_ok;
	logic [5:0]  bit_count_inc;
	logic [31:0] shift_word_inc;
	logic [7:0]  quiet_inc;
	logic        frame_ok;
	logic        edge_kept;

	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			address_a_q     <= nec_pkg::ADDRESS_A_RESET;
			address_b_q     <= nec_pkg::ADDRESS_B_RESET;
			channel_mask_q  <= nec_pkg::CHANNEL_MASK_RESET;
			glitch_filter_q <= nec_pkg::GLITCH_FILTER_RESET;
			timeout_ticks_q <= nec_pkg::TIMEOUT_TICKS_RESET;
			repeat_delay_q  <= nec_pkg::REPEAT_DELAY_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				nec_pkg::REG_ADDRESS_A:     address_a_q     <= cfg_wdata;
				nec_pkg::REG_ADDRESS_B:     address_b_q     <= cfg_wdata;
				nec_pkg::REG_CHANNEL_MASK:  channel_mask_q  <= cfg_wdata[7:0];
				nec_pkg::REG_GLITCH_FILTER: glitch_filter_q <= cfg_wdata[0];
				nec_pkg::REG_TIMEOUT_TICKS: timeout_ticks_q <= cfg_wdata[7:0];
				nec_pkg::REG_REPEAT_DELAY:  repeat_delay_q  <= cfg_wdata[2:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			func_s1     <= s_tuser;
			interval_s1 <= s_tdata;
		end
	end

	assign bit_ok = (interval_s1 < nec_pkg::BIT_BELOW) && (interval_s1 > nec_pkg::BIT_ABOVE);
	assign bit_count_inc = bit_ok ? bit_count_q + 6'd1 : bit_count_q;
	assign shift_word_inc = bit_ok ?
		{(interval_s1 >= nec_pkg::BIT_ONE_MIN), shift_word_q[31:1]} : shift_word_q;
	assign frame_ok = ((shift_word_inc[15:0] == address_a_q) ||
		(shift_word_inc[15:0] == address_b_q)) &&
		((shift_word_inc[31:24] ^ channel_mask_q) == shift_word_inc[23:16]);
	assign quiet_inc = quiet_ticks_q + 8'd1;
	assign edge_kept = !(glitch_filter_q && (interval_s1 <= nec_pkg::GLITCH_MAX));

	always_comb begin
		phase_d          = phase_q;
		shift_word_d     = shift_word_q;
		bit_count_d      = bit_count_q;
		repeat_command_d = repeat_command_q;
		repeat_left_d    = repeat_left_q;
		quiet_ticks_d    = quiet_ticks_q;
		if (func_s1) begin
			if (quiet_inc >= timeout_ticks_q) begin
				phase_d          = nec_pkg::PH_IDLE;
				shift_word_d     = '0;
				bit_count_d      = '0;
				repeat_command_d = '0;
				repeat_left_d    = '0;
				quiet_ticks_d    = '0;
			end else begin
				quiet_ticks_d = quiet_inc;
			end
		end else if (edge_kept) begin
			quiet_ticks_d = '0;
			unique case (phase_q)
				nec_pkg::PH_IDLE: begin
					phase_d = nec_pkg::PH_LEADER;
				end
				nec_pkg::PH_LEADER: begin
					if ((interval_s1 < nec_pkg::LEADER_BELOW) &&
						(interval_s1 > nec_pkg::LEADER_ABOVE)) begin
						shift_word_d = '0;
						bit_count_d  = '0;
						phase_d      = nec_pkg::PH_CODE;
					end else begin
						phase_d = nec_pkg::PH_IDLE;
					end
				end
				nec_pkg::PH_CODE: begin
					bit_count_d  = bit_count_inc;
					shift_word_d = shift_word_inc;
					if (bit_count_inc == nec_pkg::FRAME_BITS) begin
						if (frame_ok) begin
							bit_count_d  = '0;
							shift_word_d = '0;
							phase_d      = nec_pkg::PH_REP1;
							if (nec_pkg::is_repeatable(shift_word_inc[23:16])) begin
								repeat_left_d    = repeat_delay_q;
								repeat_command_d = shift_word_inc[23:16];
							end else begin
								repeat_left_d    = '0;
								repeat_command_d = '0;
							end
						end else begin
							phase_d = nec_pkg::PH_IDLE;
						end
					end
				end
				nec_pkg::PH_REP1: begin
					phase_d = nec_pkg::PH_REP2;
				end
				nec_pkg::PH_REP2: begin
					if ((interval_s1 <= nec_pkg::REPEAT_MAX) &&
						(interval_s1 >= nec_pkg::REPEAT_MIN)) begin
						if (repeat_command_q != '0) begin
							phase_d = nec_pkg::PH_REP1;
							if (repeat_left_q != '0) begin
								repeat_left_d = repeat_left_q - 3'd1;
							end
						end else begin
							phase_d = nec_pkg::PH_IDLE;
						end
					end
				end
				default: begin
					phase_d = nec_pkg::PH_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		emit          = 1'b0;
		emit_command  = shift_word_inc[23:16];
		emit_repeated = 1'b0;
		if (!func_s1 && edge_kept) begin
			unique case (phase_q)
				nec_pkg::PH_CODE: begin
					emit = (bit_count_inc == nec_pkg::FRAME_BITS) && frame_ok;
				end
				nec_pkg::PH_REP2: begin
					emit_command  = repeat_command_q;
					emit_repeated = 1'b1;
					emit = (interval_s1 <= nec_pkg::REPEAT_MAX) &&
						(interval_s1 >= nec_pkg::REPEAT_MIN) &&
						(repeat_command_q != '0) && (repeat_left_q == '0);
				end
				default: begin
					emit = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q          <= nec_pkg::PH_IDLE;
			shift_word_q     <= '0;
			bit_count_q      <= '0;
			repeat_command_q <= '0;
			repeat_left_q    <= '0;
			quiet_ticks_q    <= '0;
		end else if (valid_s1 && advance) begin
			phase_q          <= phase_d;
			shift_word_q     <= shift_word_d;
			bit_count_q      <= bit_count_d;
			repeat_command_q <= repeat_command_d;
			repeat_left_q    <= repeat_left_d;
			quiet_ticks_q    <= quiet_ticks_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && emit) begin
			out_command_q  <= emit_command;
			out_repeated_q <= emit_repeated;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_command_q;
	assign m_tuser  = out_repeated_q;

endmodule

FILE: src/nec_checker.sv
// Port-level checks for the NEC infrared frame decoder, bound to its top level.
module nec_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata,
	input logic        m_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_repeat_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> (m_tdata == nec_pkg::CMD_REP_0) ||
			(m_tdata == nec_pkg::CMD_REP_1) || (m_tdata == nec_pkg::CMD_REP_2) ||
			(m_tdata == nec_pkg::CMD_REP_3))
		else $error("auto-repeat of a command that does not repeat");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no result pending");

	a_reset_quiet: assert property (@(posedge clk)
		$rose(arst_n) |-> !m_tvalid)
		else $error("result valid right after reset");

endmodule

bind nec_ir_frame_decoder nec_checker u_nec_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

FILE: sim/nec_ir_checker.sv
// Scoreboard for the NEC infrared frame decoder: tracks decoder state, compares results.
`timescale 1ns / 1ps

module nec_ir_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] interval
	input  logic        s_tuser,   // [0] func
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,   // [7:0] command
	input  logic        m_tuser,   // [0] repeated
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic [7:0] command;
		logic       repeated;
	} ir_result_t;

	ir_result_t  expected_cmds[$];

	logic [15:0] addr_a;
	logic [15:0] addr_b;
	logic [7:0]  chan_mask;
	logic        filter_on;
	logic [7:0]  quiet_limit;
	logic [2:0]  repeat_skip;

	nec_pkg::phase_t phase;
	logic [31:0] frame_bits;
	logic [5:0]  bits_seen;
	logic [7:0]  held_cmd;
	logic [2:0]  skips_left;
	logic [7:0]  quiet;

	function automatic logic auto_repeats(input logic [7:0] cmd);
		case (cmd)
			nec_pkg::CMD_REP_0, nec_pkg::CMD_REP_1,
			nec_pkg::CMD_REP_2, nec_pkg::CMD_REP_3: auto_repeats = 1'b1;
			default: auto_repeats = 1'b0;
		endcase
	endfunction

	task automatic clear_decoder();
		phase = nec_pkg::PH_IDLE;
		frame_bits = '0;
		bits_seen = '0;
		held_cmd = '0;
		skips_left = '0;
		quiet = '0;
	endtask

	task automatic decode_event(input logic tick, input logic [15:0] iv);
		logic [15:0] addr;
		logic [7:0]  cmd;
		logic [7:0]  chk;
		if (tick) begin
			quiet = quiet + 8'd1;
			if (quiet >= quiet_limit)
				clear_decoder();
		end else if (!(filter_on && iv <= nec_pkg::GLITCH_MAX)) begin
			quiet = '0;
			case (phase)
				nec_pkg::PH_IDLE: phase = nec_pkg::PH_LEADER;
				nec_pkg::PH_LEADER: begin
					if (iv < nec_pkg::LEADER_BELOW && iv > nec_pkg::LEADER_ABOVE) begin
						frame_bits = '0;
						bits_seen = '0;
						phase = nec_pkg::PH_CODE;
					end else begin
						phase = nec_pkg::PH_IDLE;
					end
				end
				nec_pkg::PH_CODE: begin
					if (iv > nec_pkg::BIT_ABOVE && iv < nec_pkg::BIT_BELOW) begin
						bits_seen = bits_seen + 6'd1;
						frame_bits = frame_bits >> 1;
						if (iv >= nec_pkg::BIT_ONE_MIN)
							frame_bits[31] = 1'b1;
					end
					if (bits_seen == nec_pkg::FRAME_BITS) begin
						addr = frame_bits[15:0];
						cmd = frame_bits[23:16];
						chk = frame_bits[31:24];
						if ((addr == addr_a || addr == addr_b) &&
							(chk ^ chan_mask) == cmd) begin
							bits_seen = '0;
							phase = nec_pkg::PH_REP1;
							if (auto_repeats(cmd)) begin
								skips_left = repeat_skip;
								held_cmd = cmd;
							end else begin
								skips_left = '0;
								held_cmd = '0;
							end
							frame_bits = '0;
							expected_cmds.push_back('{command: cmd, repeated: 1'b0});
						end else begin
							phase = nec_pkg::PH_IDLE;
						end
					end
				end
				nec_pkg::PH_REP1: phase = nec_pkg::PH_REP2;
				nec_pkg::PH_REP2: begin
					if (iv <= nec_pkg::REPEAT_MAX && iv >= nec_pkg::REPEAT_MIN) begin
						if (held_cmd != 8'd0) begin
							phase = nec_pkg::PH_REP1;
							if (skips_left != 3'd0)
								skips_left = skips_left - 3'd1;
							else
								expected_cmds.push_back('{command: held_cmd, repeated: 1'b1});
						end else begin
							phase = nec_pkg::PH_IDLE;
						end
					end
				end
				default: phase = nec_pkg::PH_IDLE;
			endcase
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		ir_result_t want;
		if (!arst_n) begin
			addr_a = nec_pkg::ADDRESS_A_RESET;
			addr_b = nec_pkg::ADDRESS_B_RESET;
			chan_mask = nec_pkg::CHANNEL_MASK_RESET;
			filter_on = nec_pkg::GLITCH_FILTER_RESET;
			quiet_limit = nec_pkg::TIMEOUT_TICKS_RESET;
			repeat_skip = nec_pkg::REPEAT_DELAY_RESET;
			clear_decoder();
			expected_cmds.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_cmds.size() == 0) begin
					$display("%0t: result expected none actual command %02h repeated %0b",
						$time, m_tdata, m_tuser);
					fail_count++;
				end else begin
					want = expected_cmds.pop_front();
					if (m_tdata !== want.command) begin
						$display("%0t: command expected %02h actual %02h",
							$time, want.command, m_tdata);
						fail_count++;
					end
					if (m_tuser !== want.repeated) begin
						$display("%0t: repeated expected %0b actual %0b",
							$time, want.repeated, m_tuser);
						fail_count++;
					end
				end
			end
			if (s_tvalid && s_tready)
				decode_event(s_tuser, s_tdata);
			if (cfg_we) begin
				case (cfg_index)
					nec_pkg::REG_ADDRESS_A:     addr_a = cfg_wdata;
					nec_pkg::REG_ADDRESS_B:     addr_b = cfg_wdata;
					nec_pkg::REG_CHANNEL_MASK:  chan_mask = cfg_wdata[7:0];
					nec_pkg::REG_GLITCH_FILTER: filter_on = cfg_wdata[0];
					nec_pkg::REG_TIMEOUT_TICKS: quiet_limit = cfg_wdata[7:0];
					nec_pkg::REG_REPEAT_DELAY:  repeat_skip = cfg_wdata[2:0];
					default: ;
				endcase
			end
			pending = expected_cmds.size();
		end
	end

endmodule

FILE: sim/tb_top.sv
// Testbench top for the NEC infrared frame decoder: clock, reset, stimulus, pacing and verdict.
`timescale 1ns / 1ps

module tb_top;

	localparam int IDLE_LIMIT = 2000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;   // [15:0] interval
	logic        s_tuser;   // [0] func
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;   // [7:0] command
	logic        m_tuser;   // [0] repeated
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_wdata;

	int          fail_count;
	int          pending;
	int          sent_items;
	int          idle_cycles;
	int          ready_hold;
	logic        steady;

	logic [15:0] addr_a;
	logic [15:0] addr_b;
	logic [7:0]  chan_mask;
	logic        filter_on;
	logic [7:0]  quiet_limit;
	logic [2:0]  repeat_skip;

	nec_ir_frame_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	nec_ir_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55)
			pick_gap = 0;
		else if (r < 90)
			pick_gap = $urandom_range(1, 3);
		else if (r < 98)
			pick_gap = $urandom_range(4, 12);
		else
			pick_gap = $urandom_range(20, 60);
	endfunction

	always @(negedge clk) begin
		if (arst_n) begin
			if (steady) begin
				m_tready <= 1'b1;
			end else if (ready_hold > 0) begin
				ready_hold <= ready_hold - 1;
			end else if (m_tready) begin
				ready_hold <= pick_gap();
				m_tready <= 1'b0;
			end else begin
				ready_hold <= $urandom_range(0, 6);
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("nec_ir_frame_decoder regression: fail");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	task automatic send_event(input logic tick, input logic [15:0] iv);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= tick;
		s_tdata <= iv;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
		if (tick || !filter_on || iv > nec_pkg::GLITCH_MAX)
			sent_items++;
	endtask

	// ticks below the timeout and glitches sprinkled between edges
	task automatic send_edge(input logic [15:0] iv);
		int n;
		if (quiet_limit > 8'd1 && $urandom_range(0, 99) < 6) begin
			n = $urandom_range(1, (quiet_limit - 1 > 5) ? 5 : quiet_limit - 1);
			repeat (n)
				send_event(1'b1, 16'($urandom));
		end
		if ($urandom_range(0, 99) < 4)
			send_event(1'b0, 16'($urandom_range(0, 1)));
		send_event(1'b0, iv);
	endtask

	task automatic send_bit(input logic one);
		if ($urandom_range(0, 99) < 8) begin
			if ($urandom_range(0, 1) == 0)
				send_edge(16'($urandom_range(2, 8)));
			else
				send_edge(16'($urandom_range(30, 99)));
		end
		if (one)
			send_edge(16'($urandom_range(nec_pkg::BIT_ONE_MIN, nec_pkg::BIT_BELOW - 1)));
		else
			send_edge(16'($urandom_range(nec_pkg::BIT_ABOVE + 1, nec_pkg::BIT_ONE_MIN - 1)));
	endtask

	task automatic send_frame_group();
		logic [15:0] addr;
		logic [7:0]  cmd;
		logic [7:0]  chk;
		logic [31:0] word;
		int          reps;
		int          r;
		steady = ($urandom_range(0, 3) == 0);
		if ($urandom_range(0, 9) != 0)
			repeat (quiet_limit)
				send_event(1'b1, 16'($urandom));
		send_edge(16'($urandom_range(2, 65535)));
		if ($urandom_range(0, 9) == 0) begin
			case ($urandom_range(0, 2))
				0: send_edge(nec_pkg::LEADER_ABOVE);
				1: send_edge(nec_pkg::LEADER_BELOW);
				default: send_edge(16'($urandom_range(2, 65535)));
			endcase
		end else begin
			send_edge(16'($urandom_range(nec_pkg::LEADER_ABOVE + 1,
				nec_pkg::LEADER_BELOW - 1)));
		end
		r = $urandom_range(0, 99);
		addr = (r < 45) ? addr_a : (r < 85) ? addr_b : 16'($urandom);
		if ($urandom_range(0, 1) == 0) begin
			case ($urandom_range(0, 3))
				0: cmd = nec_pkg::CMD_REP_0;
				1: cmd = nec_pkg::CMD_REP_1;
				2: cmd = nec_pkg::CMD_REP_2;
				default: cmd = nec_pkg::CMD_REP_3;
			endcase
		end else begin
			cmd = 8'($urandom);
		end
		chk = ($urandom_range(0, 99) < 85) ? (cmd ^ chan_mask) : 8'($urandom);
		word = {chk, cmd, addr};
		for (int i = 0; i < 32; i++)
			send_bit(word[i]);
		reps = $urandom_range(0, 12);
		repeat (reps) begin
			send_edge(16'($urandom_range(nec_pkg::REPEAT_MAX + 1, 65535)));
			if ($urandom_range(0, 7) == 0) begin
				if ($urandom_range(0, 1) == 0)
					send_edge(16'($urandom_range(2, nec_pkg::REPEAT_MIN - 1)));
				else
					send_edge(16'($urandom_range(nec_pkg::REPEAT_MAX + 1, 400)));
			end
			send_edge(16'($urandom_range(nec_pkg::REPEAT_MIN, nec_pkg::REPEAT_MAX)));
		end
	endtask

	task automatic run_phase(input int n);
		int target;
		target = sent_items + n;
		while (sent_items < target)
			send_frame_group();
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		steady = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input nec_pkg::reg_index_t idx, input logic [15:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(negedge clk);
	endtask

	task automatic apply_settings(input logic [15:0] a, input logic [15:0] b,
			input logic [7:0] mask, input logic filt, input logic [7:0] tmo,
			input logic [2:0] dly);
		addr_a = a;
		addr_b = b;
		chan_mask = mask;
		filter_on = filt;
		quiet_limit = tmo;
		repeat_skip = dly;
		write_reg(nec_pkg::REG_ADDRESS_A, a);
		write_reg(nec_pkg::REG_ADDRESS_B, b);
		write_reg(nec_pkg::REG_CHANNEL_MASK, {8'd0, mask});
		write_reg(nec_pkg::REG_GLITCH_FILTER, {15'd0, filt});
		write_reg(nec_pkg::REG_TIMEOUT_TICKS, {8'd0, tmo});
		write_reg(nec_pkg::REG_REPEAT_DELAY, {13'd0, dly});
		cfg_we <= 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = nec_pkg::REG_ADDRESS_A;
		cfg_wdata = '0;
		sent_items = 0;
		idle_cycles = 0;
		ready_hold = 0;
		steady = 1'b0;
		addr_a = nec_pkg::ADDRESS_A_RESET;
		addr_b = nec_pkg::ADDRESS_B_RESET;
		chan_mask = nec_pkg::CHANNEL_MASK_RESET;
		filter_on = nec_pkg::GLITCH_FILTER_RESET;
		quiet_limit = nec_pkg::TIMEOUT_TICKS_RESET;
		repeat_skip = nec_pkg::REPEAT_DELAY_RESET;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// glitches, bad leaders at both bounds, bad and edge-case bits
		send_event(1'b0, 16'd0);
		send_event(1'b0, nec_pkg::GLITCH_MAX);
		send_event(1'b1, 16'd0);
		send_event(1'b0, 16'hFFFF);
		send_event(1'b0, nec_pkg::LEADER_ABOVE);
		send_event(1'b0, 16'd2);
		send_event(1'b0, nec_pkg::LEADER_BELOW);
		send_event(1'b1, 16'hFFFF);
		send_event(1'b0, 16'h5555);
		send_event(1'b0, nec_pkg::LEADER_ABOVE + 16'd1);
		send_event(1'b0, nec_pkg::BIT_ABOVE);
		send_event(1'b0, nec_pkg::BIT_BELOW);
		send_event(1'b0, nec_pkg::BIT_ABOVE + 16'd1);
		send_event(1'b0, nec_pkg::BIT_ONE_MIN - 16'd1);
		send_event(1'b0, nec_pkg::BIT_ONE_MIN);
		send_event(1'b0, nec_pkg::BIT_BELOW - 16'd1);
		send_event(1'b0, 16'd0);
		send_event(1'b1, 16'hAAAA);
		send_event(1'b1, 16'h5555);

		run_phase(200);
		drain();
		apply_settings(16'h0000, 16'hFFFF, 8'h00, 1'b0, 8'd1, 3'd0);
		run_phase(250);
		drain();
		apply_settings(16'hFFFF, 16'h0000, 8'hFF, 1'b1, 8'd255, 3'd7);
		run_phase(500);
		repeat (4) begin
			drain();
			apply_settings(16'($urandom), 16'($urandom), 8'($urandom),
				1'($urandom_range(0, 1)),
				($urandom_range(0, 4) == 0) ? 8'($urandom_range(41, 255))
					: 8'($urandom_range(2, 40)),
				3'($urandom_range(0, 7)));
			run_phase(130);
		end
		drain();
		repeat (8) @(negedge clk);

		if (fail_count == 0)
			$display("nec_ir_frame_decoder regression: pass");
		else
			$display("nec_ir_frame_decoder regression: fail");
		$finish;
	end

endmodule
